FILE: rtl/tvv_pkg.sv
package tvv_pkg;

    localparam logic [2:0] TAG_C = 3'd0;
    localparam logic [2:0] TAG_N = 3'd1;
    localparam logic [2:0] TAG_T = 3'd2;
    localparam logic [2:0] TAG_R = 3'd3;
    localparam logic [2:0] TAG_V = 3'd4;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_BAD_C   = 3'd1;
    localparam logic [2:0] STAT_BAD_T   = 3'd2;
    localparam logic [2:0] STAT_BAD_V   = 3'd3;
    localparam logic [2:0] STAT_BAD_R   = 3'd4;
    localparam logic [2:0] STAT_UNKNOWN = 3'd5;

    localparam logic [4:0] LEN_C     = 5'd6;
    localparam logic [4:0] LEN_T     = 5'd13;
    localparam logic [4:0] LEN_V     = 5'd15;
    localparam logic [4:0] COUNT_MAX = 5'd16;

    localparam logic [4:0] POS_CENTURY = 5'd1;
    localparam logic [4:0] POS_YEAR    = 5'd3;
    localparam logic [4:0] POS_MONTH   = 5'd5;
    localparam logic [4:0] POS_DAY     = 5'd7;
    localparam logic [4:0] POS_DASH    = 5'd8;
    localparam logic [4:0] POS_HOUR    = 5'd10;
    localparam logic [4:0] POS_MINUTE  = 5'd12;
    localparam logic [4:0] POS_SECOND  = 5'd14;

    localparam logic [7:0] CHAR_DASH = 8'h2d;

    localparam logic [6:0] MAX_HOUR   = 7'd24;
    localparam logic [6:0] MAX_MINSEC = 7'd59;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] units);
        return ({3'b000, tens} * 7'd10) + {3'b000, units};
    endfunction

    // zero for a month that does not exist
    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
            7'd2:                                       days = leap ? 5'd29 : 5'd28;
            default:                                    days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

FILE: rtl/tag_value_validator_core.sv
// tag_value_validator_core
// Checks one tag value, one character per request, and reports a verdict
// on the request marked last. The request channel (req_valid/req_ready)
// carries tag, ch, first, last and empty_value; the result channel
// (res_valid/res_ready) carries valid_res and status.
// A request is captured into an input register, then evaluated against the
// running value state; the verdict of the request marked last is registered
// into the result register and shown on res_valid until res_ready takes it.
// One request is taken per cycle while req_ready is high; the throughput is
// set by the single evaluation stage, which updates the state as requests fire.
// Requests without last never wait on the result side. A request with last
// waits in the input register while an earlier result is held by a stalled
// receiver; req_ready falls only then, and the held result stays unchanged.
// Reset empties both registers and returns the value state to its cleared
// form, as if the next request carried first.
module tag_value_validator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] tag,
    input  logic [7:0] ch,
    input  logic       first,
    input  logic       last,
    input  logic       empty_value,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       valid_res,
    output logic [2:0] status
);
    import tvv_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] s1_tag_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    logic       s1_empty_reg;

    logic [4:0] count_reg, count_next;
    logic       ok_reg, ok_next;
    logic [7:0] lead_reg, lead_next;
    logic       in_pair_reg, in_pair_next;
    logic [3:0] tens_reg, tens_next;
    logic [6:0] century_reg, century_next;
    logic [6:0] year_reg, year_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] day_reg, day_next;
    logic [6:0] hour_reg, hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;

    logic       res_valid_reg, res_valid_next;
    logic       valid_res_reg;
    logic [2:0] status_reg;

    logic       go;
    logic       fire;
    logic       load_res;
    logic [4:0] pos;
    logic [4:0] time_len;
    logic [3:0] digit;
    logic [6:0] dval;
    logic       leap;
    logic [4:0] max_day;
    logic       time_ok;
    logic [2:0] stat;

    assign go        = !s1_last_reg || !res_valid_reg || res_ready;
    assign fire      = s1_valid_reg && go;
    assign req_ready = !s1_valid_reg || go;
    assign load_res  = fire && s1_last_reg;

    assign s1_valid_next  = (s1_valid_reg && !go) || (req_valid && req_ready);
    assign res_valid_next = (res_valid_reg && !res_ready) || load_res;

    always_comb
    begin
        pos          = s1_first_reg ? 5'd0 : count_reg;
        count_next   = pos;
        ok_next      = s1_first_reg ? 1'b1 : ok_reg;
        lead_next    = s1_first_reg ? 8'd0 : lead_reg;
        in_pair_next = s1_first_reg ? 1'b0 : in_pair_reg;
        tens_next    = s1_first_reg ? 4'd0 : tens_reg;
        century_next = s1_first_reg ? 7'd0 : century_reg;
        year_next    = s1_first_reg ? 7'd0 : year_reg;
        month_next   = s1_first_reg ? 7'd0 : month_reg;
        day_next     = s1_first_reg ? 7'd0 : day_reg;
        hour_next    = s1_first_reg ? 7'd0 : hour_reg;
        minute_next  = s1_first_reg ? 7'd0 : minute_reg;
        second_next  = s1_first_reg ? 7'd0 : second_reg;
        time_len     = (s1_tag_reg == TAG_T) ? LEN_T : LEN_V;
        digit        = s1_ch_reg[3:0];
        dval         = two_digit(tens_next, digit);

        if (!s1_empty_reg)
        begin
            if (pos < COUNT_MAX)
            begin
                count_next = pos + 5'd1;
            end
            case (s1_tag_reg)
                TAG_C:
                begin
                    if ((pos >= LEN_C) || !is_alnum(s1_ch_reg))
                    begin
                        ok_next = 1'b0;
                    end
                end
                TAG_T, TAG_V:
                begin
                    if (pos >= time_len)
                    begin
                        ok_next = 1'b0;
                    end
                    else if (pos == POS_DASH)
                    begin
                        if (s1_ch_reg != CHAR_DASH)
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    else if (!is_digit(s1_ch_reg))
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        case (pos)
                            POS_CENTURY: century_next = dval;
                            POS_YEAR:    year_next    = dval;
                            POS_MONTH:   month_next   = dval;
                            POS_DAY:     day_next     = dval;
                            POS_HOUR:    hour_next    = dval;
                            POS_MINUTE:  minute_next  = dval;
                            POS_SECOND:  second_next  = dval;
                            default:     tens_next    = digit;
                        endcase
                    end
                end
                TAG_R:
                begin
                    if (!in_pair_next)
                    begin
                        if ((s1_ch_reg != CHAR_DASH) && !is_alnum(s1_ch_reg))
                        begin
                            ok_next = 1'b0;
                        end
                        lead_next    = s1_ch_reg;
                        in_pair_next = 1'b1;
                    end
                    else
                    begin
                        if (lead_next == CHAR_DASH)
                        begin
                            if (s1_ch_reg != CHAR_DASH)
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        else if (!is_digit(s1_ch_reg))
                        begin
                            ok_next = 1'b0;
                        end
                        in_pair_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // verdict on the state after this request's character
    always_comb
    begin
        leap    = (year_next != 7'd0) ? (year_next[1:0] == 2'b00)
                                      : (century_next[1:0] == 2'b00);
        max_day = month_days(month_next, leap);
        time_ok = ok_next && (count_next == time_len) && (max_day != 5'd0)
                  && (day_next <= {2'b00, max_day})
                  && (hour_next <= MAX_HOUR)
                  && !((hour_next == MAX_HOUR) && (minute_next != 7'd0))
                  && (minute_next <= MAX_MINSEC)
                  && ((s1_tag_reg != TAG_V) || (second_next <= MAX_MINSEC));
        case (s1_tag_reg)
            TAG_C:   stat = (ok_next && (count_next == LEN_C)) ? STAT_OK : STAT_BAD_C;
            TAG_N:   stat = STAT_OK;
            TAG_T:   stat = time_ok ? STAT_OK : STAT_BAD_T;
            TAG_V:   stat = time_ok ? STAT_OK : STAT_BAD_V;
            TAG_R:   stat = (ok_next && !in_pair_next) ? STAT_OK : STAT_BAD_R;
            default: stat = STAT_UNKNOWN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= 5'd0;
            ok_reg        <= 1'b1;
            lead_reg      <= 8'd0;
            in_pair_reg   <= 1'b0;
            tens_reg      <= 4'd0;
            century_reg   <= 7'd0;
            year_reg      <= 7'd0;
            month_reg     <= 7'd0;
            day_reg       <= 7'd0;
            hour_reg      <= 7'd0;
            minute_reg    <= 7'd0;
            second_reg    <= 7'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                count_reg   <= count_next;
                ok_reg      <= ok_next;
                lead_reg    <= lead_next;
                in_pair_reg <= in_pair_next;
                tens_reg    <= tens_next;
                century_reg <= century_next;
                year_reg    <= year_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_tag_reg   <= tag;
            s1_ch_reg    <= ch;
            s1_first_reg <= first;
            s1_last_reg  <= last;
            s1_empty_reg <= empty_value;
        end
        if (load_res)
        begin
            valid_res_reg <= (stat == STAT_OK);
            status_reg    <= stat;
        end
    end

    assign res_valid = res_valid_reg;
    assign valid_res = valid_res_reg;
    assign status    = status_reg;

endmodule

FILE: rtl/tvv_checker.sv
module tvv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       last,
    input logic       res_valid,
    input logic       res_ready,
    input logic       valid_res,
    input logic [2:0] status
);
    import tvv_pkg::*;

    // a held result stays up while the receiver stalls
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(valid_res))
        else $error("result changed while stalled");

    // verdict bit and status agree
    a_verdict_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (valid_res == (status == STAT_OK)))
        else $error("valid_res disagrees with status");

    // only defined status codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status <= STAT_UNKNOWN))
        else $error("undefined status code");

    // last request taken with no result up: res_valid follows via s1 and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && last && !res_valid |=> ##1 res_valid)
        else $error("missing result after last request");

endmodule

bind tag_value_validator_core tvv_checker u_tvv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .last      (last),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .valid_res (valid_res),
    .status    (status)
);
